### sv/sfp_pkg.sv
package sfp_pkg;

	localparam int WIN_DEPTH = 4;
	localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
	localparam int IDX_W     = $clog2(WIN_DEPTH);
	localparam int OUT_W     = 24;

	localparam logic [7:0] HDR_BYTE = 8'h55;

	// event codes
	localparam logic [7:0] EV_COMM_SET  = 8'h05;
	localparam logic [7:0] EV_COMM_CLR  = 8'h06;
	localparam logic [7:0] EV_ESTOP_SET = 8'h07;
	localparam logic [7:0] EV_ESTOP_CLR = 8'h08;
	localparam logic [7:0] EV_HEARTBEAT = 8'h0E;

	// heartbeat state codes (detail bits 2..0)
	localparam logic [2:0] HB_COMM_ERR = 3'd4;
	localparam logic [2:0] HB_ESTOP    = 3'd5;

	localparam int CUTOFF_BIT = 6;

	typedef struct packed {
		logic [7:0] code;
		logic [7:0] detail;
		logic [7:0] status;
	} sfp_frame_t;

	typedef struct packed {
		logic       comm_fault;
		logic       estop;
		logic       cutoff;
		logic [2:0] latches;   // timeout, protocol, checksum
	} sfp_flags_t;

endpackage

### sv/status_frame_parser_core.sv
// Result: m_axis_tvalid rises once the checksum byte has gone through the byte
//   register and its result has been written into the result register.
// Throughput: one byte transfer per cycle; the byte register stalls only when a
//   checksum byte completes a frame while the result register is still held.
// Reset: arst_n clears the window count, status flags, error latches and both
//   valid bits at once; held window bytes and result payload are not reset.
module status_frame_parser_core
	import sfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [7:0] event_code, [15:8] ev_detail, [16] comm_fault, [17] estop_active,
	// [18] movement_cutoff, [19] timeout_latched, [20] protocol_latched,
	// [21] checksum_latched, [23:22] zero
	output logic [OUT_W-1:0] m_axis_tdata
);

	// input byte register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic       hit;
	logic       out_free;
	logic       advance;
	sfp_frame_t frame;
	sfp_flags_t flags_next;

	// A byte leaves the input register unless it would emit a result into a busy
	// result register; bytes that emit nothing always move on.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!hit || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			byte_s1 <= s_axis_tdata;
	end

	// window, header resync and checksum
	sfp_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (byte_s1),
		.advance (advance),
		.hit     (hit),
		.frame   (frame)
	);

	// frame decode and flag state
	sfp_flags u_flags (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame      (frame),
		.commit     (advance && hit),
		.flags_next (flags_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && hit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit)
			out_data_q <= {2'b00,
				flags_next.latches[0], flags_next.latches[1], flags_next.latches[2],
				flags_next.cutoff, flags_next.estop, flags_next.comm_fault,
				frame.detail, frame.code};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

### sv/sfp_window.sv
module sfp_window
	import sfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       hit,
	output sfp_frame_t frame
);

	logic [7:0]       win_q [WIN_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [7:0]       csum;
	logic [7:0]       rest [WIN_DEPTH];
	logic             full;

	assign full = (count_q >= CNT_W'(WIN_DEPTH));
	assign csum = win_q[0] ^ win_q[1] ^ win_q[2] ^ win_q[3];
	assign hit  = full && (csum == rx_byte);

	assign frame.code   = win_q[1];
	assign frame.detail = win_q[2];
	assign frame.status = win_q[3];

	always_comb begin
		rest[0] = win_q[1];
		rest[1] = win_q[2];
		rest[2] = win_q[3];
		rest[3] = rx_byte;
	end

	// count and held bytes; held bytes need no reset, only entries below count are read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			priority if (count_q == '0) begin
				if (rx_byte == HDR_BYTE)
					count_q <= CNT_W'(1);
			end else if (!full) begin
				count_q <= count_q + CNT_W'(1);
			end else if (hit) begin
				count_q <= '0;
			end else if (rest[0] == HDR_BYTE) begin
				count_q <= CNT_W'(4);
			end else if (rest[1] == HDR_BYTE) begin
				count_q <= CNT_W'(3);
			end else if (rest[2] == HDR_BYTE) begin
				count_q <= CNT_W'(2);
			end else if (rest[3] == HDR_BYTE) begin
				count_q <= CNT_W'(1);
			end else begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			priority if (count_q == '0) begin
				win_q[0] <= rx_byte;
			end else if (!full) begin
				win_q[count_q[IDX_W-1:0]] <= rx_byte;
			end else if (hit) begin
				win_q[0] <= win_q[0];
			end else if (rest[0] == HDR_BYTE) begin
				for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= rest[i];
			end else if (rest[1] == HDR_BYTE) begin
				win_q[0] <= rest[1];
				win_q[1] <= rest[2];
				win_q[2] <= rest[3];
			end else if (rest[2] == HDR_BYTE) begin
				win_q[0] <= rest[2];
				win_q[1] <= rest[3];
			end else begin
				win_q[0] <= rest[3];
			end
		end
	end

endmodule

### sv/sfp_flags.sv
module sfp_flags
	import sfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  sfp_frame_t frame,
	input  logic       commit,
	output sfp_flags_t flags_next
);

	sfp_flags_t flags_q;
	logic [2:0] hb_state;

	assign hb_state = frame.detail[2:0];

	always_comb begin
		flags_next        = flags_q;
		flags_next.cutoff = frame.status[CUTOFF_BIT];
		unique case (frame.code)
			EV_COMM_SET:  flags_next.comm_fault = 1'b1;
			EV_COMM_CLR:  flags_next.comm_fault = 1'b0;
			EV_ESTOP_SET: flags_next.estop = 1'b1;
			EV_ESTOP_CLR: flags_next.estop = 1'b0;
			EV_HEARTBEAT: begin
				flags_next.latches = frame.detail[7:5];
				flags_next.estop   = (hb_state == HB_ESTOP);
				if (hb_state == HB_COMM_ERR)
					flags_next.comm_fault = 1'b1;
				else if (hb_state != HB_ESTOP)
					flags_next.comm_fault = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (commit) begin
			flags_q <= flags_next;
		end
	end

endmodule

### sv/sfp_checker.sv
module sfp_checker
	import sfp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_W-1:22] == '0)
		else $error("result padding not zero");

	a_hb_estop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[7:0] == EV_HEARTBEAT
		|-> m_axis_tdata[17] == (m_axis_tdata[10:8] == HB_ESTOP))
		else $error("heartbeat estop mismatch");

	a_comm_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[7:0] == EV_COMM_SET |-> m_axis_tdata[16])
		else $error("comm error not set by its event");

endmodule

bind status_frame_parser_core sfp_checker u_sfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### tb/sv/tb_status_frame_parser_core.sv
module tb_status_frame_parser_core;
	import sfp_pkg::*;

	// Bit 16 of the result word: comm_fault, 17: estop, 18: cutoff,
	// 19..21: timeout, protocol and checksum latches.
	typedef struct {
		logic [7:0] code;
		logic [7:0] detail;
		sfp_flags_t flags;
	} parsed_frame_t;

	// Tracks the receive window and the status flags. Every byte transfer
	// goes in here, and every result transfer is checked against the
	// oldest frame that is still waiting.
	class frame_tracker;
		logic [7:0]    window [WIN_DEPTH];
		int            held;
		sfp_flags_t    flags;
		parsed_frame_t expected_frames [$];
		int            fail_count;

		function new();
			held       = 0;
			flags      = '0;
			fail_count = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			fail_count++;
		endtask

		task note_byte(logic [7:0] b);
			logic [7:0]    tail [WIN_DEPTH];
			int            first;
			parsed_frame_t f;
			if (held == 0) begin
				// empty window: anything but a header is thrown away
				if (b == HDR_BYTE) begin
					window[0] = b;
					held      = 1;
				end
			end else if (held < WIN_DEPTH) begin
				window[held] = b;
				held++;
			end else if ((window[0] ^ window[1] ^ window[2] ^ window[3]) == b) begin
				flags.cutoff = window[3][CUTOFF_BIT];
				case (window[1])
					EV_COMM_SET:  flags.comm_fault = 1'b1;
					EV_COMM_CLR:  flags.comm_fault = 1'b0;
					EV_ESTOP_SET: flags.estop = 1'b1;
					EV_ESTOP_CLR: flags.estop = 1'b0;
					EV_HEARTBEAT: begin
						flags.latches = window[2][7:5];
						flags.estop   = (window[2][2:0] == HB_ESTOP);
						// comm error is kept only when the heartbeat reports estop
						if (window[2][2:0] == HB_COMM_ERR)
							flags.comm_fault = 1'b1;
						else if (window[2][2:0] != HB_ESTOP)
							flags.comm_fault = 1'b0;
					end
					default: ;
				endcase
				f.code   = window[1];
				f.detail = window[2];
				f.flags  = flags;
				expected_frames.push_back(f);
				held = 0;
			end else begin
				// bad checksum: drop the header, restart on the next 0x55 if any
				tail[0] = window[1];
				tail[1] = window[2];
				tail[2] = window[3];
				tail[3] = b;
				first   = WIN_DEPTH;
				for (int i = WIN_DEPTH - 1; i >= 0; i--)
					if (tail[i] == HDR_BYTE)
						first = i;
				held = 0;
				for (int i = first; i < WIN_DEPTH; i++) begin
					window[held] = tail[i];
					held++;
				end
			end
		endtask

		task check_frame(logic [OUT_W-1:0] d);
			parsed_frame_t e;
			if (expected_frames.size() == 0) begin
				report($sformatf("result %h with no frame pending", d));
				return;
			end
			e = expected_frames.pop_front();
			if (d[7:0] !== e.code)
				report($sformatf("event_code %h, want %h", d[7:0], e.code));
			if (d[15:8] !== e.detail)
				report($sformatf("ev_detail %h, want %h", d[15:8], e.detail));
			if (d[16] !== e.flags.comm_fault)
				report($sformatf("comm_fault %b, want %b", d[16], e.flags.comm_fault));
			if (d[17] !== e.flags.estop)
				report($sformatf("estop_active %b, want %b", d[17], e.flags.estop));
			if (d[18] !== e.flags.cutoff)
				report($sformatf("movement_cutoff %b, want %b", d[18], e.flags.cutoff));
			if (d[19] !== e.flags.latches[2])
				report($sformatf("timeout_latched %b, want %b", d[19], e.flags.latches[2]));
			if (d[20] !== e.flags.latches[1])
				report($sformatf("protocol_latched %b, want %b", d[20], e.flags.latches[1]));
			if (d[21] !== e.flags.latches[0])
				report($sformatf("checksum_latched %b, want %b", d[21], e.flags.latches[0]));
		endtask
	endclass

	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_BYTES = 500;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata  = 8'h00;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	frame_tracker tracker;
	int           src_idle     = 0;   // percent of cycles the sender holds off
	int           dst_stall    = 0;   // percent of cycles the receiver stalls
	int           sent_bytes   = 0;
	int           quiet_cycles = 0;
	logic [7:0]   event_codes [5] = '{EV_COMM_SET, EV_COMM_CLR, EV_ESTOP_SET,
		EV_ESTOP_CLR, EV_HEARTBEAT};

	status_frame_parser_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= dst_stall);
	end

	// transfer monitor; a result comes out only after its checksum byte has passed the byte
	// register and the result register, so the order of the two checks within one edge does not matter
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			tracker.check_frame(m_axis_tdata);
		if (s_axis_tvalid && s_axis_tready)
			tracker.note_byte(s_axis_tdata);
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("FAIL status_frame_parser_core");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_bytes++;
	endtask

	// flip != 0 corrupts the checksum byte
	task automatic send_frame(input logic [7:0] code, input logic [7:0] detail,
			input logic [7:0] status, input logic [7:0] flip);
		send_byte(HDR_BYTE);
		send_byte(code);
		send_byte(detail);
		send_byte(status);
		send_byte(HDR_BYTE ^ code ^ detail ^ status ^ flip);
	endtask

	task automatic send_random_chunk();
		int         pick;
		logic [7:0] code;
		logic [7:0] detail;
		pick   = $urandom_range(99);
		code   = ($urandom_range(99) < 60) ? event_codes[$urandom_range(4)] : 8'($urandom);
		detail = 8'($urandom);
		if (code == EV_HEARTBEAT && $urandom_range(1))
			detail[2:0] = $urandom_range(1) ? HB_COMM_ERR : HB_ESTOP;
		if (pick < 70) begin
			send_frame(code, detail, 8'($urandom), 8'h00);
		end else if (pick < 80) begin
			send_frame(code, detail, 8'($urandom), 8'($urandom_range(255, 1)));
		end else if (pick < 90) begin
			repeat ($urandom_range(3, 1))
				send_byte(($urandom_range(7) == 0) ? HDR_BYTE : 8'($urandom));
		end else begin
			// stray header and junk ahead of a good frame: forces a resync
			send_byte(HDR_BYTE);
			repeat ($urandom_range(2))
				send_byte(8'($urandom));
			send_frame(code, detail, 8'($urandom), 8'h00);
		end
	endtask

	initial begin
		tracker = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// junk before any header is discarded
		send_byte(8'h00);
		send_byte(8'hFF);
		// heartbeat: all latches set, comm error state, cutoff clear
		send_frame(EV_HEARTBEAT, 8'hE4, 8'hBF, 8'h00);
		// heartbeat: estop state keeps comm error, latches clear, cutoff set
		send_frame(EV_HEARTBEAT, 8'h05, 8'h40, 8'h00);
		send_frame(EV_ESTOP_SET, 8'hFF, 8'hFF, 8'h00);
		// bad checksum with no header left in the window
		send_frame(EV_ESTOP_CLR, 8'h00, 8'hFF, 8'h01);
		// stray header right before a frame
		send_byte(HDR_BYTE);
		send_frame(EV_COMM_CLR, 8'h00, 8'h00, 8'h00);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle = 0;  dst_stall = 0;  end
				1: begin src_idle = 84; dst_stall = 0;  end
				2: begin src_idle = 0;  dst_stall = 84; end
				default: begin src_idle = 26; dst_stall = 26; end
			endcase
			while (sent_bytes < PHASE_BYTES * (phase + 1))
				send_random_chunk();
		end
		s_axis_tvalid <= 1'b0;

		while (tracker.expected_frames.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.fail_count == 0)
			$display("PASS status_frame_parser_core");
		else
			$display("FAIL status_frame_parser_core");
		$finish;
	end

endmodule

### filelist.f
sv/sfp_pkg.sv
sv/sfp_window.sv
sv/sfp_flags.sv
sv/status_frame_parser_core.sv
sv/sfp_checker.sv
tb/sv/tb_status_frame_parser_core.sv
